// ===== rtl/core/npr_pkg.sv =====
// ----------------------------------------------------------------------------
// npr_pkg
// Shared widths, map constants, codes and types of the nearest point ranker.
// ----------------------------------------------------------------------------
package npr_pkg;

   // field widths
   localparam int LAT_W      = 28;
   localparam int LON_W      = 29;
   localparam int IDX_W      = 16;
   localparam int DIST_W     = 16;
   localparam int QUERY_W    = 11;
   localparam int EMIT_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // register reset values
   localparam logic [QUERY_W-1:0] QUERY_RESET = 11'd1024;
   localparam logic [EMIT_W-1:0]  EMIT_RESET  = 7'd21;

   // register index codes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUERY_X    = 2'd0,
      CSR_QUERY_Y    = 2'd1,
      CSR_EMIT_COUNT = 2'd2
   } npr_csr_type;

   // map edges in hundred-thousandths of a degree
   localparam int NORTH_EDGE = 5361858;
   localparam int SOUTH_EDGE = 5340953;
   localparam int WEST_EDGE  = -11368652;
   localparam int EAST_EDGE  = -11333496;

   // divisor magnitudes; the row axis runs against latitude
   localparam int LON_DIV = EAST_EDGE - WEST_EDGE;
   localparam int LAT_DIV = NORTH_EDGE - SOUTH_EDGE;

   // coordinate datapath widths
   localparam int T_W       = 30;   // offset from the map edge, signed
   localparam int P_W       = 32;   // scaled magnitude
   localparam int P_SHIFT   = 15;   // low bits dropped before the reciprocal
   localparam int PH_W      = P_W - P_SHIFT;
   localparam int RECIP_W   = 18;
   localparam int EST_SHIFT = P_W - P_SHIFT;
   localparam int Q_W       = 17;   // pixel magnitude
   localparam int R_W       = 18;   // remainder before correction
   localparam int DIFF_W    = DIST_W + 1;

   // reciprocals of the divisors, scaled by 2^P_W
   localparam longint unsigned LON_RECIP = (64'd1 << P_W) / LON_DIV;
   localparam longint unsigned LAT_RECIP = (64'd1 << P_W) / LAT_DIV;

   // a pixel magnitude at or past this always saturates the distance
   localparam int PIX_LIM = (2 ** DIST_W) + (2 ** QUERY_W) - 1;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [DIFF_W-1:0] DIFF_SAT = {1'b1, {DIST_W{1'b0}}};

   // front pipeline and queue
   localparam int FRONT_STAGES = 5;
   localparam int FLIGHT_W     = 3;
   localparam int QUEUE_DEPTH  = 8;
   localparam int QPTR_W       = 3;
   localparam int QCNT_W       = 4;

   // one classified record between front and back
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              last;
   } npr_entry_type;

   // register file contents
   typedef struct packed {
      logic [QUERY_W-1:0] query_x;
      logic [QUERY_W-1:0] query_y;
      logic [EMIT_W-1:0]  emit_count;
   } npr_cfg_type;

endpackage

// ===== rtl/core/npr_if.sv =====
// ----------------------------------------------------------------------------
// npr_if
// Valid/ready channels of the nearest point ranker: records in, ranks out.
// ----------------------------------------------------------------------------
interface npr_req_if import npr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] latitude;
   logic signed [LON_W-1:0] longitude;
   logic                    last_record;

   modport source (output valid, output latitude, output longitude, output last_record,
                   input ready);
   modport sink   (input valid, input latitude, input longitude, input last_record,
                   output ready);
endinterface

interface npr_rsp_if import npr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  record_index;
   logic [DIST_W-1:0] manhattan_distance;
   logic              last_result;

   modport source (output valid, output record_index, output manhattan_distance,
                   output last_result, input ready);
   modport sink   (input valid, input record_index, input manhattan_distance,
                   input last_result, output ready);
endinterface

// ===== rtl/core/npr_axis.sv =====
// ----------------------------------------------------------------------------
// npr_axis
// One map axis: offset to pixel by constant scale and division, then the
// absolute pixel distance to the query coordinate. Five register stages.
// ----------------------------------------------------------------------------
module npr_axis import npr_pkg::*; #(
   parameter int              MAP_SIZE = 2048,
   parameter int              DIV      = 35156,
   parameter longint unsigned RECIP    = 122168,
   parameter bit              NEGATE   = 1'b0
) (
   input  logic                clock,
   input  logic signed [T_W-1:0] offset,
   input  logic [QUERY_W-1:0]  query,
   output logic [DIFF_W-1:0]   diff
);

   // offsets at or past this limit land far enough off the map to saturate
   localparam longint unsigned T_LIM = (longint'(PIX_LIM) * DIV + MAP_SIZE - 1) / MAP_SIZE;
   localparam int              A_W   = $clog2(T_LIM);
   localparam int              E_W   = PH_W + RECIP_W;

   logic [T_W-1:0]   mag;
   logic [A_W-1:0]   mag_in, mag_ff;
   logic             neg_in, far_in;
   logic [3:0]       neg_ff, far_ff;
   logic [P_W-1:0]   prod_in, prod_ff, prod2_ff;
   logic [E_W-1:0]   est_full;
   logic [Q_W-1:0]   est_in, est_ff, est2_ff;
   logic [P_W-1:0]   back_prod;
   logic [R_W-1:0]   rem_in, rem_ff;
   logic [Q_W-1:0]   fix, quot;
   logic [DIFF_W-1:0] qext, diff_in, diff_ff;

   // stage 1: magnitude, pixel sign and far flag
   always_comb begin
      mag    = offset[T_W-1] ? T_W'(-offset) : T_W'(offset);
      neg_in = offset[T_W-1] ^ NEGATE;
      far_in = (mag >= T_W'(T_LIM));
      mag_in = mag[A_W-1:0];
   end

   // stage 2: scale to map size
   assign prod_in = P_W'(mag_ff) * P_W'(MAP_SIZE);

   // stage 3: quotient estimate from the reciprocal, low by at most three
   always_comb begin
      est_full = E_W'(prod_ff[P_W-1:P_SHIFT]) * E_W'(RECIP);
      est_in   = Q_W'(est_full >> EST_SHIFT);
   end

   // stage 4: remainder of the estimate
   always_comb begin
      back_prod = P_W'(P_W'(est_ff) * P_W'(DIV));
      rem_in    = R_W'(prod2_ff - back_prod);
   end

   // stage 5: correct the quotient and take the distance to the query
   always_comb begin
      fix  = Q_W'(rem_ff >= R_W'(DIV)) + Q_W'(rem_ff >= R_W'(2 * DIV))
           + Q_W'(rem_ff >= R_W'(3 * DIV));
      quot = est2_ff + fix;
      qext = DIFF_W'(query);
      if (far_ff[3]) begin
         diff_in = DIFF_SAT;
      end else if (neg_ff[3]) begin
         diff_in = DIFF_W'(quot) + qext;
      end else if (DIFF_W'(quot) >= qext) begin
         diff_in = DIFF_W'(quot) - qext;
      end else begin
         diff_in = qext - DIFF_W'(quot);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= {neg_ff[2:0], neg_in};
      far_ff   <= {far_ff[2:0], far_in};
      prod_ff  <= prod_in;
      prod2_ff <= prod_ff;
      est_ff   <= est_in;
      est2_ff  <= est_ff;
      rem_ff   <= rem_in;
      diff_ff  <= diff_in;
   end

   assign diff = diff_ff;

endmodule

// ===== rtl/core/npr_front.sv =====
// ----------------------------------------------------------------------------
// npr_front
// Accepts records, maps both coordinates and forms the saturated Manhattan
// distance. Accepts only while the queue has a slot for every word in flight.
// ----------------------------------------------------------------------------
module npr_front import npr_pkg::*; #(
   parameter int MAP_SIZE = 2048
) (
   input  logic              clock,
   input  logic              reset,
   npr_req_if.sink           req,
   input  npr_cfg_type       cfg,
   input  logic [QCNT_W-1:0] queue_level,
   output logic              push_valid,
   output npr_entry_type     push_entry
);

   logic                    accept;
   logic [FLIGHT_W-1:0]     in_flight;
   logic [FRONT_STAGES-1:0] valid_ff, valid_in;
   logic [FRONT_STAGES-1:0] last_ff, last_in;
   logic signed [T_W-1:0]   lon_off, lat_off;
   logic [DIFF_W-1:0]       dx, dy;
   logic [DIFF_W:0]         sum;

   // credit check against queue space
   assign in_flight = FLIGHT_W'($countones(valid_ff));
   assign req.ready = ((QCNT_W+1)'(queue_level) + (QCNT_W+1)'(in_flight))
                    < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept    = req.valid && req.ready;

   // offsets from the map edges
   assign lon_off = T_W'(req.longitude) - T_W'(WEST_EDGE);
   assign lat_off = T_W'(req.latitude) - T_W'(NORTH_EDGE);

   npr_axis #(
      .MAP_SIZE (MAP_SIZE),
      .DIV      (LON_DIV),
      .RECIP    (LON_RECIP),
      .NEGATE   (1'b0)
   ) u_axis_x (
      .clock  (clock),
      .offset (lon_off),
      .query  (cfg.query_x),
      .diff   (dx)
   );

   npr_axis #(
      .MAP_SIZE (MAP_SIZE),
      .DIV      (LAT_DIV),
      .RECIP    (LAT_RECIP),
      .NEGATE   (1'b1)
   ) u_axis_y (
      .clock  (clock),
      .offset (lat_off),
      .query  (cfg.query_y),
      .diff   (dy)
   );

   // tags travel alongside the axis stages
   assign valid_in = {valid_ff[FRONT_STAGES-2:0], accept};
   assign last_in  = {last_ff[FRONT_STAGES-2:0], req.last_record};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   // saturated sum into the queue
   always_comb begin
      sum                 = (DIFF_W+1)'(dx) + (DIFF_W+1)'(dy);
      push_entry.distance = (sum > (DIFF_W+1)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
      push_entry.last     = last_ff[FRONT_STAGES-1];
      push_valid          = valid_ff[FRONT_STAGES-1];
   end

endmodule

// ===== rtl/core/npr_queue.sv =====
// ----------------------------------------------------------------------------
// npr_queue
// Short first-in first-out queue of classified records between front and back.
// ----------------------------------------------------------------------------
module npr_queue import npr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  npr_entry_type     push_entry,
   input  logic              pop,
   output npr_entry_type     head,
   output logic              not_empty,
   output logic [QCNT_W-1:0] level
);

   npr_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] level_ff, level_in;

   // pointer and level update; the front never pushes into a full queue
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (level_ff != '0);
   assign level     = level_ff;

endmodule

// ===== rtl/core/npr_back.sv =====
// ----------------------------------------------------------------------------
// npr_back
// Sorted list of the nearest records: compare-and-shift insertion of one
// record a cycle, then at the end of a run the leading entries are shifted
// out through the result register, one word a cycle while rsp.ready is high.
// ----------------------------------------------------------------------------
module npr_back import npr_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  npr_entry_type     head,
   input  logic              not_empty,
   output logic              pop,
   input  logic [EMIT_W-1:0] emit_count,
   npr_rsp_if.source         rsp
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (EMIT_W > CW) ? EMIT_W : CW;

   typedef enum logic [1:0] {
      ST_INSERT = 2'b01,
      ST_EMIT   = 2'b10
   } npr_state_type;

   npr_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff [CAPACITY];
   logic [IDX_W-1:0]  idx_in [CAPACITY];
   logic [DIST_W-1:0] dist_ff [CAPACITY];
   logic [DIST_W-1:0] dist_in [CAPACITY];
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     left_ff, left_in;
   logic [IDX_W-1:0]  arrival_ff, arrival_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CAPACITY-1:0] le;
   logic                drop, load;
   logic [CW-1:0]       count_ins, count_next, n_emit;

   // which entries stay ahead of the new record (equal ones stay ahead)
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         le[k] = (CW'(k) < count_ff) && (dist_ff[k] <= head.distance);
      end
      drop       = le[CAPACITY-1];
      count_ins  = (count_ff < CW'(CAPACITY)) ? count_ff + 1'b1 : count_ff;
      count_next = drop ? count_ff : count_ins;
      n_emit     = (MW'(emit_count) < MW'(count_next)) ? CW'(emit_count) : count_next;
   end

   assign pop  = (state_ff == ST_INSERT) && not_empty;
   assign load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   // list update, run control and result register
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      dist_in      = dist_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      arrival_in   = arrival_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_INSERT: begin
            if (not_empty) begin
               if (!drop) begin
                  if (!le[0]) begin
                     idx_in[0]  = arrival_ff;
                     dist_in[0] = head.distance;
                  end
                  for (int k = 1; k < CAPACITY; k++) begin
                     if (!le[k]) begin
                        if (le[k-1]) begin
                           idx_in[k]  = arrival_ff;
                           dist_in[k] = head.distance;
                        end else begin
                           idx_in[k]  = idx_ff[k-1];
                           dist_in[k] = dist_ff[k-1];
                        end
                     end
                  end
                  count_in = count_ins;
               end
               arrival_in = arrival_ff + 1'b1;
               // end of run: start emitting or, with nothing to emit, restart
               if (head.last) begin
                  arrival_in = '0;
                  if (n_emit == '0) begin
                     count_in = '0;
                  end else begin
                     state_in = ST_EMIT;
                     left_in  = n_emit;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff[0];
               rsp_dist_in  = dist_ff[0];
               rsp_last_in  = (left_ff == CW'(1));
               for (int k = 0; k < CAPACITY - 1; k++) begin
                  idx_in[k]  = idx_ff[k+1];
                  dist_in[k] = dist_ff[k+1];
               end
               left_in = left_ff - 1'b1;
               if (left_ff == CW'(1)) begin
                  state_in = ST_INSERT;
                  count_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_INSERT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INSERT;
         count_ff     <= '0;
         left_ff      <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         arrival_ff   <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      dist_ff     <= dist_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.record_index       = rsp_idx_ff;
   assign rsp.manhattan_distance = rsp_dist_ff;
   assign rsp.last_result        = rsp_last_ff;

endmodule

// ===== rtl/core/nearest_point_rank_manhattan.sv =====
// ----------------------------------------------------------------------------
// nearest_point_rank_manhattan
// Ranks point records by saturated Manhattan pixel distance to a query point.
// ----------------------------------------------------------------------------
// Records enter one per cycle while the eight-entry queue has room and
// pass through the registered coordinate mapping pipeline into the queue.
// The rank list takes one record per cycle from the queue (a parallel
// compare-and-shift over all CAPACITY entries) while it is not emitting,
// so a run of N records sustains one record per cycle. On the record marked
// last_record the list then sends min(emit_count, entries held) words, one
// per cycle while rsp_chan.ready is high, nearest first and equal distances
// in arrival order; records of the next run collect in the queue meanwhile.
// A run whose emit count is zero ends without any word. The user must write
// the registers only while the block is idle; the block does not enforce it.
module nearest_point_rank_manhattan import npr_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int MAP_SIZE = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   npr_req_if.sink               req_chan,
   npr_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   npr_cfg_type       cfg_ff, cfg_in;
   logic              push_valid;
   npr_entry_type     push_entry;
   npr_entry_type     head;
   logic              not_empty;
   logic              pop;
   logic [QCNT_W-1:0] queue_level;

   // register writes; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_QUERY_X:    cfg_in.query_x    = csr_write_data[QUERY_W-1:0];
            CSR_QUERY_Y:    cfg_in.query_y    = csr_write_data[QUERY_W-1:0];
            CSR_EMIT_COUNT: cfg_in.emit_count = csr_write_data[EMIT_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.query_x    <= QUERY_RESET;
         cfg_ff.query_y    <= QUERY_RESET;
         cfg_ff.emit_count <= EMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   npr_front #(
      .MAP_SIZE (MAP_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .cfg         (cfg_ff),
      .queue_level (queue_level),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   npr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .level      (queue_level)
   );

   npr_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .emit_count (cfg_ff.emit_count),
      .rsp        (rsp_chan)
   );

endmodule

// ===== rtl/core/npr_checker.sv =====
// ----------------------------------------------------------------------------
// npr_checker
// Port-level checks of the ranker's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module npr_checker import npr_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [IDX_W-1:0]  rsp_record_index,
   input logic [DIST_W-1:0] rsp_distance,
   input logic              rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic              rsp_fire;
   logic              mid_run_ff, mid_run_in;
   logic [DIST_W-1:0] prev_dist_ff, prev_dist_in;
   logic [CW-1:0]     words_ff, words_in;

   assign rsp_fire = rsp_valid && rsp_ready;

   // track position within the current ranking
   always_comb begin
      mid_run_in   = mid_run_ff;
      prev_dist_in = prev_dist_ff;
      words_in     = words_ff;
      if (rsp_fire) begin
         mid_run_in   = !rsp_last;
         prev_dist_in = rsp_distance;
         words_in     = rsp_last ? '0 : words_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_run_ff <= 1'b0;
         words_ff   <= '0;
      end else begin
         mid_run_ff <= mid_run_in;
         words_ff   <= words_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_dist_ff <= prev_dist_in;
   end

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record_index)
                                  && $stable(rsp_distance) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // no word straight out of reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a ranking comes out nearest first
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && mid_run_ff |-> rsp_distance >= prev_dist_ff)
      else $error("ranking out of order");

   // a ranking never holds more than the list
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> words_ff < CW'(CAPACITY))
      else $error("ranking longer than the list");

endmodule

bind nearest_point_rank_manhattan npr_checker #(
   .CAPACITY (CAPACITY)
) u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_record_index (rsp_chan.record_index),
   .rsp_distance     (rsp_chan.manhattan_distance),
   .rsp_last         (rsp_chan.last_result)
);

// ===== tb/npr_rank_checker.sv =====
// ----------------------------------------------------------------------------
// npr_rank_checker
// Watches the record, rank and register ports of the nearest point ranker,
// keeps its own copy of the rank list and checks every rank word in order.
// ----------------------------------------------------------------------------
module npr_rank_checker import npr_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int MAP_SIZE = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   npr_req_if                    req_mon,
   npr_rsp_if                    rsp_mon,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    rank_failures,
   output int                    ranks_waiting
);

   typedef struct packed {
      logic [IDX_W-1:0]  record_index;
      logic [DIST_W-1:0] manhattan_distance;
      logic              last_result;
   } rank_word_type;

   // register mirror and rank list copy
   npr_cfg_type       cfg;
   logic [IDX_W-1:0]  ranked_idx  [CAPACITY];
   logic [DIST_W-1:0] ranked_dist [CAPACITY];
   int                ranked_total;
   logic [IDX_W-1:0]  next_arrival;

   rank_word_type     expected_ranks [$];
   rank_word_type     seen_word;
   rank_word_type     want_word;
   int                error_total;
   int                emit_n;
   int                slot;

   // pixel mapping with truncation toward zero, then saturated manhattan distance
   function automatic logic [DIST_W-1:0] pixel_distance(input logic signed [LAT_W-1:0] lat,
                                                        input logic signed [LON_W-1:0] lon);
      longint lat_l;
      longint lon_l;
      longint col;
      longint row;
      longint qx;
      longint qy;
      longint dx;
      longint dy;
      longint dist_sum;
      lat_l = lat;
      lon_l = lon;
      qx    = cfg.query_x;
      qy    = cfg.query_y;
      col   = (lon_l - WEST_EDGE) * MAP_SIZE / (EAST_EDGE - WEST_EDGE);
      row   = (lat_l - NORTH_EDGE) * MAP_SIZE / (SOUTH_EDGE - NORTH_EDGE);
      dx    = col - qx;
      dy    = row - qy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      dist_sum = dx + dy;
      if (dist_sum > longint'(DIST_MAX)) dist_sum = longint'(DIST_MAX);
      return dist_sum[DIST_W-1:0];
   endfunction

   // stable insert after equal distances, farthest entry falls off a full list
   function automatic void rank_insert(input logic [IDX_W-1:0] idx,
                                       input logic [DIST_W-1:0] new_dist);
      int pos;
      int k;
      pos = 0;
      while (pos < ranked_total && ranked_dist[pos] <= new_dist) pos++;
      if (pos >= CAPACITY) return;
      k = (ranked_total < CAPACITY) ? ranked_total : CAPACITY - 1;
      while (k > pos) begin
         ranked_idx[k]  = ranked_idx[k-1];
         ranked_dist[k] = ranked_dist[k-1];
         k--;
      end
      ranked_idx[pos]  = idx;
      ranked_dist[pos] = new_dist;
      if (ranked_total < CAPACITY) ranked_total++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.query_x    = QUERY_RESET;
         cfg.query_y    = QUERY_RESET;
         cfg.emit_count = EMIT_RESET;
         ranked_total   = 0;
         next_arrival   = '0;
         error_total    = 0;
         expected_ranks.delete();
      end else begin
         // rank word out: compare with the oldest expected word
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_word = {rsp_mon.record_index, rsp_mon.manhattan_distance,
                         rsp_mon.last_result};
            if (expected_ranks.size() == 0) begin
               $display("%0t unexpected rank word: index %0d distance %0d last %0b",
                        $time, seen_word.record_index, seen_word.manhattan_distance,
                        seen_word.last_result);
               error_total++;
            end else begin
               want_word = expected_ranks.pop_front();
               if (seen_word !== want_word) begin
                  $display("%0t rank word mismatch: expected index %0d distance %0d last %0b,",
                           $time, want_word.record_index, want_word.manhattan_distance,
                           want_word.last_result,
                           " actual index %0d distance %0d last %0b",
                           seen_word.record_index, seen_word.manhattan_distance,
                           seen_word.last_result);
                  error_total++;
               end
            end
         end

         // record in: rank it, and on the last record queue the leading entries
         if (req_mon.valid && req_mon.ready) begin
            rank_insert(next_arrival, pixel_distance(req_mon.latitude, req_mon.longitude));
            next_arrival = next_arrival + 1'b1;
            if (req_mon.last_record) begin
               emit_n = cfg.emit_count;
               if (emit_n > ranked_total) emit_n = ranked_total;
               for (slot = 0; slot < emit_n; slot++)
                  expected_ranks.push_back(rank_word_type'({ranked_idx[slot], ranked_dist[slot],
                                                           slot == emit_n - 1}));
               ranked_total = 0;
               next_arrival = '0;
            end
         end

         // register writes, unknown index ignored
         if (csr_write_enable) begin
            case (csr_index)
               CSR_QUERY_X:    cfg.query_x    = csr_write_data[QUERY_W-1:0];
               CSR_QUERY_Y:    cfg.query_y    = csr_write_data[QUERY_W-1:0];
               CSR_EMIT_COUNT: cfg.emit_count = csr_write_data[EMIT_W-1:0];
               default: ;
            endcase
         end
      end
      ranks_waiting <= expected_ranks.size();
      rank_failures <= error_total;
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives point records through the nearest point ranker in runs of random
// length under three idle patterns and several query and emit settings; the
// rank checker beside the block predicts and compares every rank word.
// ----------------------------------------------------------------------------
module testbench import npr_pkg::*; ();

   localparam int CAPACITY      = 64;
   localparam int MAP_SIZE      = 2048;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS   = 75;
   localparam int MID_LAT       = (NORTH_EDGE + SOUTH_EDGE) / 2;
   localparam int MID_LON       = (WEST_EDGE + EAST_EDGE) / 2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    rank_failures;
   int                    ranks_waiting;
   int                    tx_idle_pct;
   int                    rx_idle_pct;
   int                    cycle_count = 0;
   int                    items_sent  = 0;

   npr_req_if req_chan ();
   npr_rsp_if rsp_chan ();

   nearest_point_rank_manhattan #(.CAPACITY(CAPACITY), .MAP_SIZE(MAP_SIZE)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   npr_rank_checker #(.CAPACITY(CAPACITY), .MAP_SIZE(MAP_SIZE)) u_rank_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rank_failures    (rank_failures),
      .ranks_waiting    (ranks_waiting)
   );

   always #1 clock = ~clock;

   // receiver stalls
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one record word, with random sender gaps ahead of it
   task automatic send_record(input int lat, input int lon, input logic last);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_chan.valid       <= 1'b1;
      req_chan.latitude    <= lat[LAT_W-1:0];
      req_chan.longitude   <= lon[LON_W-1:0];
      req_chan.last_record <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // hold the sender until every rank word is back and the block has settled
   task automatic drain_block();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (ranks_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] query_col,
                            input logic [CSR_DATA_W-1:0] query_row,
                            input logic [CSR_DATA_W-1:0] emit_val);
      drain_block();
      write_register(CSR_QUERY_X, query_col);
      write_register(CSR_QUERY_Y, query_row);
      write_register(CSR_EMIT_COUNT, emit_val);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int lat;
      int lon;
      int prev_lat;
      int prev_lon;
      int run_len;
      int phase_start;
      int pick;
      int phase;
      int k;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.latitude    = '0;
      req_chan.longitude   = '0;
      req_chan.last_record = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_QUERY_X;
      csr_write_data       = '0;
      tx_idle_pct          = 20;
      rx_idle_pct          = 54;
      prev_lat             = MID_LAT;
      prev_lon             = MID_LON;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single record run at the reset register values, map corner
      send_record(NORTH_EDGE, WEST_EDGE, 1'b1);

      // field extremes, corners, ties, truncation toward zero off the edge,
      // and a last record that ranks first
      send_record(-90000000, -180000000, 1'b0);
      send_record(90000000, 180000000, 1'b0);
      send_record(90000000, -180000000, 1'b0);
      send_record(-90000000, 180000000, 1'b0);
      send_record(SOUTH_EDGE, EAST_EDGE, 1'b0);
      send_record(NORTH_EDGE + 5, WEST_EDGE - 5, 1'b0);
      send_record(SOUTH_EDGE, EAST_EDGE, 1'b0);
      send_record(NORTH_EDGE + 30000, WEST_EDGE - 30000, 1'b0);
      send_record(MID_LAT, MID_LON, 1'b1);

      // emit count zero ends the run silently; unknown register index ignored
      drain_block();
      write_register(CSR_EMIT_COUNT, 11'd0);
      write_register(CSR_UNUSED, 11'h7FF);
      csr_write_enable <= 1'b0;
      send_record(MID_LAT, MID_LON, 1'b0);
      send_record(SOUTH_EDGE, WEST_EDGE, 1'b1);

      // emit count above capacity saturates to what the list holds
      configure(11'd1024, 11'd1024, 11'd100);
      send_record(MID_LAT + 1000, MID_LON, 1'b0);
      send_record(MID_LAT, MID_LON - 1000, 1'b0);
      send_record(MID_LAT + 1000, MID_LON, 1'b1);

      // random runs under three idle patterns
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 20;
               rx_idle_pct <= 54;
               configure(11'd0, 11'd0, 11'd64);
            end
            1: begin
               tx_idle_pct = 54;
               rx_idle_pct <= 20;
               configure(11'd2047, 11'd2047, 11'd1);
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
               configure(CSR_DATA_W'($urandom_range(2047)), CSR_DATA_W'($urandom_range(2047)),
                         CSR_DATA_W'($urandom_range(64, 1)));
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // mostly short runs, now and then one that overflows the list
            run_len = ($urandom_range(5) == 0) ? int'($urandom_range(90, 65))
                                                : int'($urandom_range(24, 1));
            for (k = 0; k < run_len; k++) begin
               pick = $urandom_range(99);
               if (pick < 60) begin
                  lat = SOUTH_EDGE + int'($urandom_range(LAT_DIV));
                  lon = WEST_EDGE + int'($urandom_range(LON_DIV));
               end else if (pick < 75) begin
                  lat = MID_LAT - 1500000 + int'($urandom_range(3000000));
                  lon = MID_LON - 1500000 + int'($urandom_range(3000000));
               end else if (pick < 85) begin
                  lat = prev_lat;
                  lon = prev_lon;
               end else begin
                  lat = int'($urandom_range(180000000)) - 90000000;
                  lon = int'($urandom_range(360000000)) - 180000000;
               end
               send_record(lat, lon, k == run_len - 1);
               prev_lat = lat;
               prev_lon = lon;
            end
            // sometimes let the block drain and move the query point
            if ($urandom_range(3) == 0)
               configure(CSR_DATA_W'($urandom_range(2047)), CSR_DATA_W'($urandom_range(2047)),
                         CSR_DATA_W'($urandom_range(64, 1)));
         end
      end

      drain_block();
      if (rank_failures == 0 && ranks_waiting == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== nearest_point_rank_manhattan.f =====
rtl/core/npr_pkg.sv
rtl/core/npr_if.sv
rtl/core/npr_axis.sv
rtl/core/npr_front.sv
rtl/core/npr_queue.sv
rtl/core/npr_back.sv
rtl/core/nearest_point_rank_manhattan.sv
rtl/core/npr_checker.sv
tb/npr_rank_checker.sv
tb/testbench.sv
